>>> hdl/aesme_pkg.sv
// ============================================================================
// aesme_pkg
// Shared types, register indexes and AES round functions for the block mode
// engine.
// ============================================================================
package aesme_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_MODE    = 3'd0;
    localparam logic [2:0] REG_KEY_LEN = 3'd1;
    localparam logic [2:0] REG_KEY0    = 3'd2;
    localparam logic [2:0] REG_KEY1    = 3'd3;
    localparam logic [2:0] REG_KEY2    = 3'd4;
    localparam logic [2:0] REG_KEY3    = 3'd5;
    localparam logic [2:0] REG_IV_HIGH = 3'd6;
    localparam logic [2:0] REG_IV_LOW  = 3'd7;

    // Mode codes
    localparam logic [2:0] MODE_CTR_DEC = 3'd5;

    // Chaining kinds (mode code without its direction bit)
    localparam logic [1:0] KIND_ECB = 2'd0;
    localparam logic [1:0] KIND_CBC = 2'd1;
    localparam logic [1:0] KIND_CTR = 2'd2;

    // Key length codes
    localparam logic [1:0] KLEN_128 = 2'd0;
    localparam logic [1:0] KLEN_192 = 2'd1;

    localparam logic [7:0] PAD_MARK    = 8'h80;
    localparam logic [4:0] BLOCK_BYTES = 5'd16;

    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
        logic        final_item;
        logic [3:0]  byte_count;
    } in_item_t;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
        logic [4:0]  valid_bytes;
        logic        pad_error;
        logic        result_last;
    } out_item_t;

    // Classified block waiting for the cipher core
    typedef struct packed {
        logic [127:0] blk;
        logic         final_item;
        logic         dec;
        logic [1:0]   kind;
    } q_entry_t;

    localparam logic [2047:0] SBOX_TABLE = {
        128'h637c777bf26b6fc53001672bfed7ab76,
        128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115,
        128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84,
        128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8,
        128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973,
        128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479,
        128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
        128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df,
        128'h8ca1890dbfe6426841992d0fb054bb16
    };

    localparam logic [2047:0] INV_SBOX_TABLE = {
        128'h52096ad53036a538bf40a39e81f3d7fb,
        128'h7ce339829b2fff87348e4344c4dee9cb,
        128'h547b9432a6c2233dee4c950b42fac34e,
        128'h082ea16628d924b2765ba2496d8bd125,
        128'h72f8f66486689816d4a45ccc5d65b692,
        128'h6c704850fdedb9da5e154657a78d9d84,
        128'h90d8ab008cbcd30af7e45805b8b34506,
        128'hd02c1e8fca3f0f02c1afbd0301138a6b,
        128'h3a9111414f67dcea97f2cfcef0b4e673,
        128'h96ac7422e7ad3585e2f937e81c75df6e,
        128'h47f11a711d29c5896fb7620eaa18be1b,
        128'hfc563e4bc6d279209adbc0fe78cd5af4,
        128'h1fdda8338807c731b11210592780ec5f,
        128'h60517fa919b54a0d2de57a9f93c99cef,
        128'ha0e03b4dae2af5b0c8ebbb3c83539961,
        128'h172b047eba77d626e169146355210c7d
    };

    function automatic logic [7:0] sbox(input logic [7:0] x);
        return SBOX_TABLE[{~x, 3'b111} -: 8];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        return INV_SBOX_TABLE[{~x, 3'b111} -: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    function automatic logic [127:0] sub_bytes(input logic [127:0] s);
        logic [127:0] t;
        for (int i = 0; i < 16; i++)
        begin
            t[8*i +: 8] = sbox(s[8*i +: 8]);
        end
        return t;
    endfunction

    function automatic logic [127:0] inv_sub_bytes(input logic [127:0] s);
        logic [127:0] t;
        for (int i = 0; i < 16; i++)
        begin
            t[8*i +: 8] = inv_sbox(s[8*i +: 8]);
        end
        return t;
    endfunction

    // Byte i of the state sits at bits [127-8i -: 8]
    function automatic logic [127:0] shift_rows(input logic [127:0] s);
        logic [127:0] t;
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                t[127 - 8*(r + 4*c) -: 8] = s[127 - 8*(r + 4*((c + r) & 3)) -: 8];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] inv_shift_rows(input logic [127:0] s);
        logic [127:0] t;
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                t[127 - 8*(r + 4*((c + r) & 3)) -: 8] = s[127 - 8*(r + 4*c) -: 8];
            end
        end
        return t;
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] w);
        logic [7:0] a [4];
        logic [31:0] t;
        for (int r = 0; r < 4; r++)
        begin
            a[r] = w[31 - 8*r -: 8];
        end
        for (int r = 0; r < 4; r++)
        begin
            t[31 - 8*r -: 8] = xtime(a[r]) ^ xtime(a[(r + 1) & 3]) ^ a[(r + 1) & 3]
                             ^ a[(r + 2) & 3] ^ a[(r + 3) & 3];
        end
        return t;
    endfunction

    function automatic logic [31:0] inv_mix_col(input logic [31:0] w);
        logic [7:0] a  [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [31:0] t;
        for (int r = 0; r < 4; r++)
        begin
            a[r]  = w[31 - 8*r -: 8];
            x2[r] = xtime(a[r]);
            x4[r] = xtime(x2[r]);
            x8[r] = xtime(x4[r]);
        end
        for (int r = 0; r < 4; r++)
        begin
            t[31 - 8*r -: 8] =
                (x8[r] ^ x4[r] ^ x2[r]) ^
                (x8[(r + 1) & 3] ^ x2[(r + 1) & 3] ^ a[(r + 1) & 3]) ^
                (x8[(r + 2) & 3] ^ x4[(r + 2) & 3] ^ a[(r + 2) & 3]) ^
                (x8[(r + 3) & 3] ^ a[(r + 3) & 3]);
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++)
        begin
            t[127 - 32*c -: 32] = mix_col(s[127 - 32*c -: 32]);
        end
        return t;
    endfunction

    function automatic logic [127:0] inv_mix_columns(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++)
        begin
            t[127 - 32*c -: 32] = inv_mix_col(s[127 - 32*c -: 32]);
        end
        return t;
    endfunction

    // Key words: 4, 6 or 8 (undefined length code acts as 256)
    function automatic logic [3:0] key_nk(input logic [1:0] klen);
        return (klen == KLEN_128) ? 4'd4 : ((klen == KLEN_192) ? 4'd6 : 4'd8);
    endfunction

    function automatic logic [3:0] key_nr(input logic [1:0] klen);
        return key_nk(klen) + 4'd6;
    endfunction

endpackage

>>> hdl/aesme_keysched.sv
// ============================================================================
// aesme_keysched
// Key expansion, one schedule word per cycle, into a round key memory with
// one registered read port for the cipher core.
// ============================================================================
module aesme_keysched
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [255:0] key,
    input  logic [1:0]   key_length,
    input  logic [3:0]   rd_addr,
    output logic [127:0] rd_data,
    output logic         busy
);

    logic         busy_reg, busy_next;
    logic [5:0]   idx_reg, idx_next;
    logic [2:0]   mod_reg, mod_next;
    logic [7:0]   rcon_reg, rcon_next;
    logic [31:0]  win_reg [8];
    logic [31:0]  acc_reg [3];
    logic [127:0] rk_mem [15];
    logic [127:0] rd_data_reg;

    logic [3:0]  nk;
    logic [2:0]  nk_m1;
    logic [5:0]  last_idx;
    logic [31:0] key_sel;
    logic [31:0] tmp;
    logic [31:0] word;

    assign nk       = aesme_pkg::key_nk(key_length);
    assign nk_m1    = 3'(nk - 4'd1);
    assign last_idx = {nk, 2'b00} + 6'd27;
    assign key_sel  = key[{~idx_reg[2:0], 5'h1f} -: 32];

    // Compute the next schedule word
    always_comb
    begin
        tmp = win_reg[0];
        if (mod_reg == 3'd0)
        begin
            tmp = aesme_pkg::sub_word({win_reg[0][23:0], win_reg[0][31:24]})
                ^ {rcon_reg, 24'h000000};
        end
        else if (nk == 4'd8 && mod_reg == 3'd4)
        begin
            tmp = aesme_pkg::sub_word(win_reg[0]);
        end
        word = (idx_reg < 6'(nk)) ? key_sel : (win_reg[nk_m1] ^ tmp);
    end

    // Advance counters
    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        mod_next  = mod_reg;
        rcon_next = rcon_reg;
        if (start)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
            mod_next  = '0;
            rcon_next = 8'h01;
        end
        else if (busy_reg)
        begin
            idx_next = idx_reg + 6'd1;
            mod_next = (mod_reg == nk_m1) ? 3'd0 : mod_reg + 3'd1;
            if (idx_reg >= 6'(nk) && mod_reg == 3'd0)
            begin
                rcon_next = aesme_pkg::xtime(rcon_reg);
            end
            if (idx_reg == last_idx)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            mod_reg  <= '0;
            rcon_reg <= 8'h01;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            mod_reg  <= mod_next;
            rcon_reg <= rcon_next;
        end
    end

    // Slide the word window and gather four words per round key
    always_ff @(posedge clk)
    begin
        if (busy_reg && !start)
        begin
            win_reg[0] <= word;
            for (int k = 1; k < 8; k++)
            begin
                win_reg[k] <= win_reg[k-1];
            end
            if (idx_reg[1:0] == 2'd3)
            begin
                rk_mem[idx_reg[5:2]] <= {acc_reg[0], acc_reg[1], acc_reg[2], word};
            end
            else
            begin
                acc_reg[idx_reg[1:0]] <= word;
            end
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= rk_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

>>> hdl/aesme_front.sv
// ============================================================================
// aesme_front
// Input side: resolves the mode, pads the final block when encrypting and
// holds classified blocks in a two-entry queue for the core.
// ============================================================================
module aesme_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  aesme_pkg::in_item_t  in_data,
    input  logic [2:0]           mode_select,
    output logic                 q_valid,
    output aesme_pkg::q_entry_t  q_data,
    input  logic                 q_pop
);

    aesme_pkg::q_entry_t fifo_reg [2];
    logic                wr_ptr_reg, rd_ptr_reg;
    logic [1:0]          count_reg, count_next;
    aesme_pkg::q_entry_t entry;
    logic [2:0]          mode_r;
    logic                push;

    // Classify the incoming beat
    always_comb
    begin
        mode_r = (mode_select > aesme_pkg::MODE_CTR_DEC) ? aesme_pkg::MODE_CTR_DEC
                                                         : mode_select;
        entry.dec        = mode_r[0];
        entry.kind       = mode_r[2:1];
        entry.final_item = in_data.final_item;
        entry.blk        = {in_data.block_high, in_data.block_low};
        if (!mode_r[0] && in_data.final_item)
        begin
            for (int i = 0; i < 16; i++)
            begin
                if (4'(i) == in_data.byte_count)
                begin
                    entry.blk[127 - 8*i -: 8] = aesme_pkg::PAD_MARK;
                end
                else if (4'(i) > in_data.byte_count)
                begin
                    entry.blk[127 - 8*i -: 8] = 8'h00;
                end
            end
        end
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_data   = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= entry;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> count_reg != 2'd0)
        else $error("pop from empty queue");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> count_reg == $past(count_reg) + 2'd1)
        else $error("queue count lost a beat");

endmodule

>>> hdl/aesme_core.sv
// ============================================================================
// aesme_core
// Cipher back end: one AES round per cycle, CBC/CTR chaining, padding check
// on final decrypted blocks and the output register.
// ============================================================================
module aesme_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  aesme_pkg::q_entry_t  q_data,
    output logic                 q_pop,
    input  logic [127:0]         iv,
    input  logic [1:0]           key_length,
    input  logic                 key_busy,
    output logic [3:0]           rk_addr,
    input  logic [127:0]         rk_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output aesme_pkg::out_item_t out_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]   state_reg, state_next;
    logic [3:0]   rnd_reg;
    logic [127:0] st_reg, st_next;
    logic [127:0] blk_reg, chn_reg;
    logic [127:0] chain_reg;
    logic         msg_start_reg;
    logic [1:0]   kind_reg;
    logic         dec_reg, cdec_reg, final_reg;
    logic         out_valid_reg;
    aesme_pkg::out_item_t out_reg;

    logic [3:0]   nr;
    logic [127:0] chn_eff, cin;
    logic         cdec_in, start, last, out_free, fin_load;
    logic [127:0] enc_step, enc_mid, dec_step, res, chain_next;
    logic         found, mark_ok;
    logic [3:0]   last_nz;
    aesme_pkg::out_item_t out_item;

    assign nr       = aesme_pkg::key_nr(key_length);
    assign start    = (state_reg == ST_IDLE) && q_valid && !key_busy;
    assign q_pop    = start;
    assign chn_eff  = msg_start_reg ? iv : chain_reg;
    assign cdec_in  = q_data.dec && (q_data.kind != aesme_pkg::KIND_CTR);
    assign last     = cdec_reg ? (rnd_reg == 4'd0) : (rnd_reg == nr);
    assign out_free = !out_valid_reg || out_ready;
    assign fin_load = (state_reg == ST_FIN) && out_free;

    // Select what enters the cipher
    always_comb
    begin
        case (q_data.kind)
            aesme_pkg::KIND_CTR: cin = chn_eff;
            aesme_pkg::KIND_CBC: cin = q_data.dec ? q_data.blk : (q_data.blk ^ chn_eff);
            default:             cin = q_data.blk;
        endcase
    end

    // One round of each direction
    always_comb
    begin
        enc_mid  = aesme_pkg::shift_rows(aesme_pkg::sub_bytes(st_reg));
        enc_step = (last ? enc_mid : aesme_pkg::mix_columns(enc_mid)) ^ rk_data;
        dec_step = aesme_pkg::inv_sub_bytes(aesme_pkg::inv_shift_rows(st_reg)) ^ rk_data;
        if (rnd_reg != 4'd0)
        begin
            dec_step = aesme_pkg::inv_mix_columns(dec_step);
        end
    end

    // Sequence the rounds
    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        rk_addr    = rnd_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    st_next    = cin;
                    rk_addr    = cdec_in ? nr : 4'd0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                st_next    = st_reg ^ rk_data;
                rk_addr    = cdec_reg ? rnd_reg - 4'd1 : rnd_reg + 4'd1;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                st_next = cdec_reg ? dec_step : enc_step;
                if (last)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    rk_addr = cdec_reg ? rnd_reg - 4'd1 : rnd_reg + 4'd1;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Combine with the chain and check padding
    always_comb
    begin
        chain_next = chn_reg;
        case (kind_reg)
            aesme_pkg::KIND_CTR:
            begin
                res        = blk_reg ^ st_reg;
                chain_next = {chn_reg[127:32], chn_reg[31:0] + 32'd1};
            end
            aesme_pkg::KIND_CBC:
            begin
                res        = dec_reg ? (st_reg ^ chn_reg) : st_reg;
                chain_next = dec_reg ? blk_reg : st_reg;
            end
            default:
            begin
                res = st_reg;
            end
        endcase

        found   = 1'b0;
        last_nz = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (res[127 - 8*i -: 8] != 8'h00)
            begin
                found   = 1'b1;
                last_nz = 4'(i);
            end
        end
        mark_ok = found && (res[{~last_nz, 3'b111} -: 8] == aesme_pkg::PAD_MARK);

        out_item.result_high = res[127:64];
        out_item.result_low  = res[63:0];
        out_item.result_last = final_reg;
        out_item.valid_bytes = aesme_pkg::BLOCK_BYTES;
        out_item.pad_error   = 1'b0;
        if (dec_reg && final_reg)
        begin
            out_item.valid_bytes = mark_ok ? {1'b0, last_nz} : 5'd0;
            out_item.pad_error   = !mark_ok;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rnd_reg       <= '0;
            msg_start_reg <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rk_addr;
            if (start)
            begin
                msg_start_reg <= q_data.final_item;
            end
            if (fin_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
        if (start)
        begin
            blk_reg   <= q_data.blk;
            chn_reg   <= chn_eff;
            kind_reg  <= q_data.kind;
            dec_reg   <= q_data.dec;
            cdec_reg  <= cdec_in;
            final_reg <= q_data.final_item;
        end
        if (fin_load)
        begin
            out_reg   <= out_item;
            chain_reg <= chain_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_run_keys_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD || state_reg == ST_RUN) |-> !key_busy)
        else $error("round keys changed during a block");

    a_fin_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        fin_load |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("finished block not registered");

    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> rnd_reg <= nr)
        else $error("round counter out of range");

    a_start_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == ST_IDLE && q_valid)
        else $error("queue popped while core busy");

endmodule

>>> hdl/aes_block_mode_engine.sv
// ============================================================================
// aes_block_mode_engine
// AES-128/192/256 block engine for ECB, CBC and CTR with ISO 7816-4 padding.
// ============================================================================
// Usage:
//   Configuration: cfg_we writes cfg_data into register cfg_index (mode,
//   key length, four key words, two IV halves). A write of the key length
//   or a key word starts key expansion, during which queued blocks wait.
//   Input: one 16-byte block per beat on in_valid/in_ready; final_item
//   closes a message and the chain reloads from the IV on the next block.
//   Output: one result beat per input beat on out_valid/out_ready, in order.
//   Processing: an accepted block passes the queue, the key load, the Nr
//   rounds and the chain/padding stage on its way to out_valid; the round
//   loop runs one AES round per cycle, and the core works on one block at
//   a time.
//   A two-entry queue takes new blocks while the core works; the result
//   register holds a finished block while the receiver stalls, and the core
//   waits with the next result until that register frees.
//   Reset: queue and output empty, mode ECB encrypt, key and IV zero;
//   the first block after reset starts a message.
// ============================================================================
module aes_block_mode_engine
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  aesme_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output aesme_pkg::out_item_t out_data,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [63:0]          cfg_data
);

    logic [2:0]   mode_reg;
    logic [1:0]   klen_reg;
    logic [255:0] key_reg;
    logic [127:0] iv_reg;
    logic         key_start;

    logic                q_valid, q_pop;
    aesme_pkg::q_entry_t q_data;
    logic [3:0]          rk_addr;
    logic [127:0]        rk_data;
    logic                key_busy;

    assign key_start = cfg_we && cfg_index >= aesme_pkg::REG_KEY_LEN
                              && cfg_index <= aesme_pkg::REG_KEY3;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= '0;
            klen_reg <= '0;
            key_reg  <= '0;
            iv_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                aesme_pkg::REG_MODE:    mode_reg         <= cfg_data[2:0];
                aesme_pkg::REG_KEY_LEN: klen_reg         <= cfg_data[1:0];
                aesme_pkg::REG_KEY0:    key_reg[255:192] <= cfg_data;
                aesme_pkg::REG_KEY1:    key_reg[191:128] <= cfg_data;
                aesme_pkg::REG_KEY2:    key_reg[127:64]  <= cfg_data;
                aesme_pkg::REG_KEY3:    key_reg[63:0]    <= cfg_data;
                aesme_pkg::REG_IV_HIGH: iv_reg[127:64]   <= cfg_data;
                aesme_pkg::REG_IV_LOW:  iv_reg[63:0]     <= cfg_data;
                default:                mode_reg         <= mode_reg;
            endcase
        end
    end

    aesme_keysched u_keysched
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (key_start),
        .key        (key_reg),
        .key_length (klen_reg),
        .rd_addr    (rk_addr),
        .rd_data    (rk_data),
        .busy       (key_busy)
    );

    aesme_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .mode_select (mode_reg),
        .q_valid     (q_valid),
        .q_data      (q_data),
        .q_pop       (q_pop)
    );

    aesme_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_data     (q_data),
        .q_pop      (q_pop),
        .iv         (iv_reg),
        .key_length (klen_reg),
        .key_busy   (key_busy),
        .rk_addr    (rk_addr),
        .rk_data    (rk_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

>>> verif/aesme_mode_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// aesme_mode_checker
// Watches the configuration, input and result channels of the AES block mode
// engine. Computes each expected result block from its own copy of the
// registers, key schedule and chain, and compares it field by field with the
// result beats as they come out.
// ============================================================================
module aesme_mode_checker
    import aesme_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  in_item_t   in_data,
    input  logic       out_valid,
    input  logic       out_ready,
    input  out_item_t  out_data,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [63:0] cfg_data,
    output int         fail_count,
    output int         pending,
    output int         checked,
    output int         pad_flags
);

    // Register copies
    logic [2:0]  mode_reg;
    logic [1:0]  klen_reg;
    logic [63:0] key_reg [4];
    logic [63:0] iv_hi_reg;
    logic [63:0] iv_lo_reg;

    // Block state
    logic [63:0] chain_hi;
    logic [63:0] chain_lo;
    logic [31:0] sched [60];
    bit          msg_open_next;

    logic [7:0]  fwd_sb [256];
    logic [7:0]  rev_sb [256];

    out_item_t   expected_results [$];
    int          fails;
    int          n_checked;
    int          n_pad;

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[0])
                r ^= a;
            a = a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
            b = b >> 1;
        end
        return r;
    endfunction

    function automatic logic [7:0] rotl(input logic [7:0] x, input int n);
        return (x << n) | (x >> (8 - n));
    endfunction

    // Build the substitution tables from the field inverse and affine map
    initial
    begin
        logic [7:0] p;
        logic [7:0] r;
        logic [7:0] s;
        for (int x = 0; x < 256; x++)
        begin
            r = 8'h01;
            p = x[7:0];
            for (int e = 254; e != 0; e >>= 1)
            begin
                if (e & 1)
                    r = gmul(r, p);
                p = gmul(p, p);
            end
            s = r ^ rotl(r, 1) ^ rotl(r, 2) ^ rotl(r, 3) ^ rotl(r, 4) ^ 8'h63;
            fwd_sb[x] = s;
            rev_sb[s] = x[7:0];
        end
    end

    function automatic int words_in_key();
        return (klen_reg == KLEN_128) ? 4 : ((klen_reg == KLEN_192) ? 6 : 8);
    endfunction

    function automatic void expand_schedule();
        int         nk;
        int         total;
        logic [7:0] rcon;
        logic [31:0] t;
        nk = words_in_key();
        total = 4 * (nk + 7);
        rcon = 8'h01;
        for (int i = 0; i < 60; i++)
        begin
            sched[i] = 32'h0;
        end
        for (int i = 0; i < nk; i++)
        begin
            sched[i] = i[0] ? key_reg[i >> 1][31:0] : key_reg[i >> 1][63:32];
        end
        for (int i = nk; i < total; i++)
        begin
            t = sched[i - 1];
            if (i % nk == 0)
            begin
                t = {t[23:0], t[31:24]};
                t = {fwd_sb[t[31:24]], fwd_sb[t[23:16]], fwd_sb[t[15:8]], fwd_sb[t[7:0]]};
                t ^= {rcon, 24'h0};
                rcon = gmul(rcon, 8'h02);
            end
            else if (nk > 6 && i % nk == 4)
            begin
                t = {fwd_sb[t[31:24]], fwd_sb[t[23:16]], fwd_sb[t[15:8]], fwd_sb[t[7:0]]};
            end
            sched[i] = sched[i - nk] ^ t;
        end
    endfunction

    // Byte i of a block sits at bits [127-8i -: 8]
    function automatic logic [127:0] add_rk(input logic [127:0] s, input int r);
        for (int c = 0; c < 4; c++)
        begin
            s[127 - 32*c -: 32] ^= sched[4*r + c];
        end
        return s;
    endfunction

    function automatic logic [127:0] subst(input logic [127:0] s, input bit inv);
        for (int i = 0; i < 16; i++)
        begin
            s[127 - 8*i -: 8] = inv ? rev_sb[s[127 - 8*i -: 8]] : fwd_sb[s[127 - 8*i -: 8]];
        end
        return s;
    endfunction

    function automatic logic [127:0] rotate_rows(input logic [127:0] s, input bit inv);
        logic [127:0] t;
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                if (inv)
                    t[127 - 8*(r + 4*((c + r) & 3)) -: 8] = s[127 - 8*(r + 4*c) -: 8];
                else
                    t[127 - 8*(r + 4*c) -: 8] = s[127 - 8*(r + 4*((c + r) & 3)) -: 8];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix(input logic [127:0] s, input bit inv);
        logic [7:0] a [4];
        logic [7:0] m0;
        logic [7:0] m1;
        logic [7:0] m2;
        logic [7:0] m3;
        m0 = inv ? 8'd14 : 8'd2;
        m1 = inv ? 8'd11 : 8'd3;
        m2 = inv ? 8'd13 : 8'd1;
        m3 = inv ? 8'd9  : 8'd1;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                a[r] = s[127 - 8*(4*c + r) -: 8];
            end
            for (int r = 0; r < 4; r++)
            begin
                s[127 - 8*(4*c + r) -: 8] = gmul(a[r], m0) ^ gmul(a[(r + 1) & 3], m1)
                                          ^ gmul(a[(r + 2) & 3], m2) ^ gmul(a[(r + 3) & 3], m3);
            end
        end
        return s;
    endfunction

    function automatic logic [127:0] aes_run(input logic [127:0] s, input bit dec);
        int nr;
        nr = words_in_key() + 6;
        if (!dec)
        begin
            s = add_rk(s, 0);
            for (int r = 1; r <= nr; r++)
            begin
                s = rotate_rows(subst(s, 0), 0);
                if (r != nr)
                    s = mix(s, 0);
                s = add_rk(s, r);
            end
        end
        else
        begin
            s = add_rk(s, nr);
            for (int r = nr - 1; r >= 0; r--)
            begin
                s = subst(rotate_rows(s, 1), 1);
                s = add_rk(s, r);
                if (r != 0)
                    s = mix(s, 1);
            end
        end
        return s;
    endfunction

    // Work out the result block for one accepted input beat
    function automatic out_item_t predict_block(input in_item_t it);
        logic [2:0]   md;
        bit           dec;
        logic [1:0]   kind;
        logic [127:0] blk;
        logic [127:0] chn;
        logic [127:0] keep;
        logic [31:0]  ctr;
        int           p;
        out_item_t    o;
        md = (mode_reg > MODE_CTR_DEC) ? MODE_CTR_DEC : mode_reg;
        dec = md[0];
        kind = md[2:1];
        if (msg_open_next)
        begin
            chain_hi = iv_hi_reg;
            chain_lo = iv_lo_reg;
            msg_open_next = 0;
        end
        blk = {it.block_high, it.block_low};
        // Pad the closing block of an encrypted message
        if (!dec && it.final_item)
        begin
            blk[127 - 8*it.byte_count -: 8] = PAD_MARK;
            for (int i = it.byte_count + 1; i < 16; i++)
            begin
                blk[127 - 8*i -: 8] = 8'h00;
            end
        end
        chn = {chain_hi, chain_lo};
        if (kind == KIND_ECB)
        begin
            blk = aes_run(blk, dec);
        end
        else if (kind == KIND_CBC)
        begin
            if (!dec)
            begin
                blk = aes_run(blk ^ chn, 0);
                keep = blk;
            end
            else
            begin
                keep = blk;
                blk = aes_run(blk, 1) ^ chn;
            end
            {chain_hi, chain_lo} = keep;
        end
        else
        begin
            ctr = chain_lo[31:0] + 32'd1;
            blk ^= aes_run(chn, 0);
            chain_lo[31:0] = ctr;
        end
        o.valid_bytes = BLOCK_BYTES;
        o.pad_error = 1'b0;
        // Strip padding on the closing block of a decrypted message
        if (dec && it.final_item)
        begin
            p = 16;
            while (p > 0 && blk[127 - 8*(p - 1) -: 8] == 8'h00)
                p--;
            if (p == 0 || blk[127 - 8*(p - 1) -: 8] != PAD_MARK)
            begin
                o.valid_bytes = 5'd0;
                o.pad_error = 1'b1;
            end
            else
            begin
                o.valid_bytes = 5'(p - 1);
            end
        end
        o.result_high = blk[127:64];
        o.result_low = blk[63:0];
        o.result_last = it.final_item;
        msg_open_next = it.final_item;
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t exp_item;
        if (!rst_n)
        begin
            mode_reg = 3'd0;
            klen_reg = KLEN_128;
            for (int i = 0; i < 4; i++)
            begin
                key_reg[i] = 64'h0;
            end
            iv_hi_reg = 64'h0;
            iv_lo_reg = 64'h0;
            chain_hi = 64'h0;
            chain_lo = 64'h0;
            msg_open_next = 1;
            expected_results.delete();
        end
        else
        begin
            // Track register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MODE:    mode_reg = cfg_data[2:0];
                    REG_KEY_LEN: begin klen_reg = cfg_data[1:0]; expand_schedule(); end
                    REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3:
                    begin
                        key_reg[cfg_index - REG_KEY0] = cfg_data;
                        expand_schedule();
                    end
                    REG_IV_HIGH: iv_hi_reg = cfg_data;
                    REG_IV_LOW:  iv_lo_reg = cfg_data;
                    default: ;
                endcase
            end
            // Predict on each input beat
            if (in_valid && in_ready)
                expected_results.push_back(predict_block(in_data));
            // Compare each result beat with the oldest expectation
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result beat %h", out_data);
                end
                else
                begin
                    exp_item = expected_results.pop_front();
                    n_checked++;
                    if (out_data.pad_error)
                        n_pad++;
                    if (out_data.result_high !== exp_item.result_high
                        || out_data.result_low !== exp_item.result_low
                        || out_data.valid_bytes !== exp_item.valid_bytes
                        || out_data.pad_error !== exp_item.pad_error
                        || out_data.result_last !== exp_item.result_last)
                    begin
                        fails++;
                        if (fails <= 10)
                        begin
                            $display("mismatch on result %0d:", n_checked);
                            $display("  data exp %h_%h act %h_%h", exp_item.result_high,
                                     exp_item.result_low, out_data.result_high,
                                     out_data.result_low);
                            $display("  valid_bytes exp %0d act %0d, pad_error exp %b act %b,"
                                     , exp_item.valid_bytes, out_data.valid_bytes,
                                     exp_item.pad_error, out_data.pad_error);
                            $display("  result_last exp %b act %b", exp_item.result_last,
                                     out_data.result_last);
                        end
                    end
                end
            end
        end
        fail_count <= fails;
        pending <= expected_results.size();
        checked <= n_checked;
        pad_flags <= n_pad;
    end

endmodule

>>> verif/aes_block_mode_engine_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// aes_block_mode_engine_tb
// Drives the AES block mode engine with encrypt messages across all modes and
// key lengths, feeds the captured ciphertext back through the matching decrypt
// mode, and mixes in broken and random blocks; a checker beside the block
// predicts and compares every result beat.
// ============================================================================
module aes_block_mode_engine_tb;
    import aesme_pkg::*;

    localparam logic [2:0] MODE_ECB_ENC = 3'd0;
    localparam logic [2:0] MODE_CBC_ENC = 3'd2;
    localparam logic [2:0] MODE_CTR_ENC = 3'd4;
    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;
    localparam logic [1:0] KLEN_256     = 2'd2;
    localparam logic [1:0] KLEN_SPARE   = 2'd3;
    localparam int         DRAIN_WAIT   = 24;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = REG_MODE;
    logic [63:0] cfg_data = 64'h0;

    int fail_count;
    int pending;
    int checked;
    int pad_flags;

    int        tx_idle_pct = 0;
    int        rx_idle_pct = 0;
    int        n_items = 0;
    bit        capturing = 0;
    out_item_t ciphertext_log [$];

    aes_block_mode_engine dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    aesme_mode_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked),
        .pad_flags  (pad_flags)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Stall the result side at random
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Keep result beats for replay through the decrypt side
    always @(posedge clk)
    begin
        if (capturing && out_valid && out_ready)
            ciphertext_log.push_back(out_data);
    end

    initial
    begin
        #4_000_000;
        $display("aes_block_mode_engine_tb: FAIL");
        $finish;
    end

    function automatic logic [63:0] pick_word();
        case ($urandom_range(9))
            0: return 64'h0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic cfg_put(input logic [2:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
    endtask

    task automatic cfg_done();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Hold the sender until every expected result is out, then let the core drain
    task automatic settle();
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic send(input in_item_t it);
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (!in_ready);
        n_items++;
    endtask

    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
                              input bit fin, input logic [3:0] cnt);
        in_item_t it;
        it.block_high = hi;
        it.block_low = lo;
        it.final_item = fin;
        it.byte_count = cnt;
        send(it);
    endtask

    task automatic load_setup(input logic [2:0] md, input logic [1:0] kl,
                              input logic [63:0] k0, input logic [63:0] k1,
                              input logic [63:0] k2, input logic [63:0] k3,
                              input logic [63:0] ivh, input logic [63:0] ivl);
        cfg_put(REG_MODE, 64'(md));
        cfg_put(REG_KEY_LEN, 64'(kl));
        cfg_put(REG_KEY0, k0);
        cfg_put(REG_KEY1, k1);
        cfg_put(REG_KEY2, k2);
        cfg_put(REG_KEY3, k3);
        cfg_put(REG_IV_HIGH, ivh);
        cfg_put(REG_IV_LOW, ivl);
        cfg_done();
    endtask

    // Send the captured ciphertext back in a decrypt mode
    task automatic replay(input logic [2:0] dec_mode, input bit split);
        out_item_t r;
        cfg_put(REG_MODE, 64'(dec_mode));
        cfg_done();
        while (ciphertext_log.size() != 0)
        begin
            r = ciphertext_log.pop_front();
            send_block(r.result_high, r.result_low, split ? 1'b1 : r.result_last,
                       4'($urandom_range(15)));
        end
        settle();
    endtask

    // Encrypt random messages, then decrypt them in the paired mode
    task automatic round_trip(input logic [2:0] enc_mode, input logic [2:0] dec_mode,
                              input logic [1:0] kl);
        int nmsg;
        int len;
        logic [63:0] ivl;
        ivl = ($urandom_range(3) == 0) ? {32'($urandom), 32'hffff_fffe} : pick_word();
        load_setup(enc_mode, kl, pick_word(), pick_word(), pick_word(), pick_word(),
                   pick_word(), ivl);
        ciphertext_log.delete();
        capturing = 1;
        nmsg = $urandom_range(1, 3);
        for (int m = 0; m < nmsg; m++)
        begin
            len = $urandom_range(1, 4);
            for (int b = 0; b < len; b++)
            begin
                send_block(pick_word(), pick_word(), b == len - 1, 4'($urandom_range(15)));
            end
        end
        settle();
        capturing = 0;
        replay(dec_mode, $urandom_range(7) == 0);
        // Noise: random blocks straight into a decrypt mode
        if ($urandom_range(2) == 0)
        begin
            for (int i = 0; i < 3; i++)
            begin
                send_block(pick_word(), pick_word(), 1'($urandom_range(1)),
                           4'($urandom_range(15)));
            end
            settle();
        end
    endtask

    initial
    begin
        logic [2:0] enc_mode;
        logic [2:0] dec_mode;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: extreme keys and data, both padding ends, zero-run error
        load_setup(MODE_ECB_ENC, KLEN_128, '1, '1, 64'h0, 64'h0, 64'h0, 64'h0);
        ciphertext_log.delete();
        capturing = 1;
        send_block(64'h0, 64'h0, 1'b0, 4'd0);
        send_block('1, '1, 1'b1, 4'd15);
        send_block(64'h0, 64'h0, 1'b1, 4'd0);
        settle();
        capturing = 0;
        replay(MODE_ECB_ENC | 3'd1, 1'b1);

        load_setup(MODE_CBC_ENC, KLEN_192, 64'h0, 64'h0, 64'h0, 64'h0, '1, '1);
        capturing = 1;
        send_block('1, 64'h0, 1'b0, 4'd7);
        send_block(64'h0, '1, 1'b1, 4'd15);
        settle();
        capturing = 0;
        replay(MODE_CBC_ENC | 3'd1, 1'b0);

        // Counter low word wraps inside the message
        load_setup(MODE_CTR_ENC, KLEN_256, '1, 64'h0, '1, 64'h0, 64'h0, 64'h0000_0000_ffff_ffff);
        capturing = 1;
        send_block(64'h0, 64'h0, 1'b0, 4'd0);
        send_block('1, '1, 1'b0, 4'd0);
        send_block(64'h0123_4567_89ab_cdef, '1, 1'b1, 4'd8);
        settle();
        capturing = 0;
        replay(MODE_SPARE_A, 1'b0);
        round_trip(MODE_CTR_ENC, MODE_SPARE_B, KLEN_SPARE);

        // Random: three idling phases
        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 33 : ((phase == 1) ? 55 : 0);
            rx_idle_pct = (phase == 0) ? 55 : ((phase == 1) ? 33 : 0);
            for (int s = 0; s < 12; s++)
            begin
                case ($urandom_range(2))
                    0: enc_mode = MODE_ECB_ENC;
                    1: enc_mode = MODE_CBC_ENC;
                    default: enc_mode = MODE_CTR_ENC;
                endcase
                dec_mode = enc_mode | 3'd1;
                if (enc_mode == MODE_CTR_ENC && $urandom_range(2) != 0)
                    dec_mode = $urandom_range(1) ? MODE_SPARE_A : MODE_SPARE_B;
                round_trip(enc_mode, dec_mode, 2'($urandom_range(3)));
            end
        end

        settle();
        $display("run covered %0d input blocks and %0d checked results over all modes,",
                 n_items, checked);
        $display("four key length codes and %0d padding errors flagged", pad_flags);
        if (fail_count == 0)
            $display("aes_block_mode_engine_tb: PASS");
        else
            $display("aes_block_mode_engine_tb: FAIL");
        $finish;
    end

endmodule
